### rtl/core/bmdu_pkg.sv
`default_nettype none

package bmdu_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned StepW = 3;

  // bus access kinds
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // register map
  localparam logic [IdxW-1:0] REG_OPA    = 2'd0;
  localparam logic [IdxW-1:0] REG_OPB    = 2'd1;
  localparam logic [IdxW-1:0] REG_OPC    = 2'd2;
  localparam logic [IdxW-1:0] REG_STATUS = 2'd3;

  // command codes written to the status/command register
  localparam logic [DataW-1:0] CMD_DIV = 8'd1;
  localparam logic [DataW-1:0] CMD_MUL = 8'd2;

  localparam logic [StepW-1:0] LAST_STEP = 3'd7;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } st_t;

  typedef struct packed {
    logic             start;
    op_t              op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic             busy;
    logic [DataW-1:0] hi;
    logic [DataW-1:0] lo;
  } alu_rsp_t;

endpackage

`default_nettype wire

### rtl/core/bmdu_alu.sv
`default_nettype none

// shift-add multiply and restoring divide over one shared adder, one bit per cycle
module bmdu_alu (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bmdu_pkg::alu_req_t req,
  output bmdu_pkg::alu_rsp_t      rsp
);

  bmdu_pkg::st_t  state;
  bmdu_pkg::st_t  state_next;
  bmdu_pkg::op_t  op;
  logic [bmdu_pkg::StepW-1:0] step;
  logic [bmdu_pkg::DataW-1:0] divisor;
  logic [bmdu_pkg::DataW-1:0] hi;
  logic [bmdu_pkg::DataW-1:0] lo;
  logic                       done;

  logic [bmdu_pkg::DataW:0]   add_x;
  logic [bmdu_pkg::DataW:0]   add_y;
  logic                       add_cin;
  logic [bmdu_pkg::DataW+1:0] add_sum;
  logic                       no_borrow;
  logic                       last;

  // shared adder: subtract for divide, conditional add for multiply
  always_comb begin
    if (op == bmdu_pkg::OP_DIV) begin
      add_x   = {hi, lo[bmdu_pkg::DataW-1]};
      add_y   = ~{1'b0, divisor};
      add_cin = 1'b1;
    end else begin
      add_x   = {1'b0, hi};
      add_y   = lo[0] ? {1'b0, divisor} : '0;
      add_cin = 1'b0;
    end
    add_sum   = {1'b0, add_x} + {1'b0, add_y} + {{(bmdu_pkg::DataW+1){1'b0}}, add_cin};
    no_borrow = add_sum[bmdu_pkg::DataW+1];
  end

  assign last = (step == bmdu_pkg::LAST_STEP);

  always_comb begin
    state_next = state;
    unique case (state)
      bmdu_pkg::ST_IDLE: if (req.start) state_next = bmdu_pkg::ST_RUN;
      bmdu_pkg::ST_RUN:  if (last) state_next = bmdu_pkg::ST_IDLE;
      default:           state_next = bmdu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmdu_pkg::ST_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == bmdu_pkg::ST_RUN) && last;
      if (state == bmdu_pkg::ST_RUN) step <= step + 1'b1;
      else step <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bmdu_pkg::ST_IDLE && req.start) begin
      op      <= req.op;
      divisor <= req.a;
      lo      <= req.c;
      if (req.op == bmdu_pkg::OP_MUL) begin
        hi <= '0;
      end else begin
        // equal high byte: quotient bit 8 is dropped, remainder starts at zero
        hi <= (req.b == req.a) ? '0 : req.b;
      end
    end else if (state == bmdu_pkg::ST_RUN) begin
      if (op == bmdu_pkg::OP_DIV) begin
        hi <= no_borrow ? add_sum[bmdu_pkg::DataW-1:0] : add_x[bmdu_pkg::DataW-1:0];
        lo <= {lo[bmdu_pkg::DataW-2:0], no_borrow};
      end else begin
        hi <= add_sum[bmdu_pkg::DataW:1];
        lo <= {add_sum[0], lo[bmdu_pkg::DataW-1:1]};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.busy = (state == bmdu_pkg::ST_RUN);
  assign rsp.hi   = hi;
  assign rsp.lo   = lo;

endmodule

`default_nettype wire

### rtl/core/bus_mul_div_unit.sv
`default_nettype none

// Byte-wide multiply/divide unit behind four registers. Each input transfer is one
// bus access: the access kind and register index travel on s_tuser, the written byte
// on s_tdata. A read of register 0-2 returns the data byte, a read of register 3
// returns the status byte (bit 0 set on error), and a write to register 3 issues a
// command (1 divides {reg1,reg2} by reg0 giving remainder in reg1 and quotient low
// byte in reg2, 2 multiplies reg0 by reg2 giving the product in {reg1,reg2}).
// Reads give one output transfer, writes give none. Reads, data writes, unknown
// commands and rejected divides do not start the unit. A multiply or divide runs
// one bit per cycle through a single shared 9-bit adder: 8 steps then a write-back,
// and s_tready stays low from the command transfer until the write-back.
// The error bit comes up set after reset and is cleared by a successful command.
module bus_mul_div_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tuser, lowest bit up: command[0], reg_index[2:1]
  input  wire logic [2:0]  s_tuser,
  // s_tdata: write_data[7:0]
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // m_tdata: read_data[7:0]
  output logic [7:0]       m_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready
);

  logic                          command;
  logic [bmdu_pkg::IdxW-1:0]     reg_index;
  logic [bmdu_pkg::DataW-1:0]    write_data;

  // data registers and status
  logic [bmdu_pkg::DataW-1:0]    operand_bytes [3];
  logic                          error_flag;
  logic                          busy;

  logic                          accept;
  logic                          is_cmd;
  logic                          div_bad;
  logic [bmdu_pkg::DataW-1:0]    read_value;

  bmdu_pkg::alu_req_t            req;
  bmdu_pkg::alu_rsp_t            rsp;

  assign command    = s_tuser[0];
  assign reg_index  = s_tuser[2:1];
  assign write_data = s_tdata[7:0];

  // output register frees the input side once its transfer is taken
  assign s_tready = !busy && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign is_cmd   = (command == bmdu_pkg::ACC_WRITE) && (reg_index == bmdu_pkg::REG_STATUS);

  // divide rejected when divisor is zero or below the high byte
  assign div_bad = (operand_bytes[0] == '0) || (operand_bytes[0] < operand_bytes[1]);

  always_comb begin
    req.start = 1'b0;
    req.op    = bmdu_pkg::OP_DIV;
    req.a     = operand_bytes[0];
    req.b     = operand_bytes[1];
    req.c     = operand_bytes[2];
    if (accept && is_cmd) begin
      if (write_data == bmdu_pkg::CMD_DIV) begin
        req.start = !div_bad;
      end else if (write_data == bmdu_pkg::CMD_MUL) begin
        req.start = 1'b1;
        req.op    = bmdu_pkg::OP_MUL;
      end
    end
  end

  bmdu_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    unique case (reg_index)
      bmdu_pkg::REG_OPA:    read_value = operand_bytes[0];
      bmdu_pkg::REG_OPB:    read_value = operand_bytes[1];
      bmdu_pkg::REG_OPC:    read_value = operand_bytes[2];
      bmdu_pkg::REG_STATUS: read_value = {{(bmdu_pkg::DataW-1){1'b0}}, error_flag};
      default:              read_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operand_bytes[0] <= '0;
      operand_bytes[1] <= '0;
      operand_bytes[2] <= '0;
      error_flag       <= 1'b1;
      busy             <= 1'b0;
      m_tvalid         <= 1'b0;
      m_tdata          <= '0;
    end else begin
      // a new read result replaces the one taken in the same cycle
      if (accept && command == bmdu_pkg::ACC_READ) begin
        m_tvalid <= 1'b1;
        m_tdata  <= read_value;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (accept && command == bmdu_pkg::ACC_WRITE) begin
        if (!is_cmd) begin
          case (reg_index)
            bmdu_pkg::REG_OPA: operand_bytes[0] <= write_data;
            bmdu_pkg::REG_OPB: operand_bytes[1] <= write_data;
            bmdu_pkg::REG_OPC: operand_bytes[2] <= write_data;
            default:           operand_bytes[0] <= operand_bytes[0];
          endcase
        end else if (req.start) begin
          busy <= 1'b1;
        end else begin
          // unknown code or rejected divide
          error_flag <= 1'b1;
        end
      end

      // write-back of the finished multiply or divide
      if (rsp.done) begin
        operand_bytes[1] <= rsp.hi;
        operand_bytes[2] <= rsp.lo;
        error_flag       <= 1'b0;
        busy             <= 1'b0;
      end
    end
  end

  // no transfer is taken while the shared unit runs
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (busy || rsp.busy) |-> !s_tready)
    else $error("input transfer taken while arithmetic unit busy");

  // a started command sets both the block busy flag and the unit busy state
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> (busy && rsp.busy))
    else $error("command started without unit running");

  // a completed command clears the error bit and the busy flag
  a_done_clears_err: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> (!error_flag && !busy))
    else $error("completed command left error or busy set");

  // done only follows the last step of a run
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(rsp.busy))
    else $error("done without a preceding run");

endmodule

`default_nettype wire
